### src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the box screen area block.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int CLIP_W     = 52;           // clip sum width
   localparam int REM_W      = CLIP_W + 1;   // divider remainder width
   localparam int FRAC_W     = 16;
   localparam int NDC_W      = 18;
   localparam int EXT_W      = 35;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW   = 2;
   localparam int OUT_DEPTH  = 8;
   localparam int OUT_AW     = 3;
   localparam int REQ_W      = 336;
   localparam int RSP_W      = 40;

   localparam logic signed [CLIP_W-1:0] NEAR_W  = CLIP_W'(6);
   localparam logic signed [NDC_W-1:0]  NDC_ONE = NDC_W'(65536);

   typedef enum logic [2:0] {
      CSR_PROJ_X_A  = 3'd0,
      CSR_PROJ_X_B  = 3'd1,
      CSR_PROJ_Y_A  = 3'd2,
      CSR_PROJ_Y_B  = 3'd3,
      CSR_PROJ_W_A  = 3'd4,
      CSR_PROJ_W_B  = 3'd5,
      CSR_PIX_SIZES = 3'd6,
      CSR_PROJ_VLD  = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [63:0] xa;
      logic [63:0] xb;
      logic [63:0] ya;
      logic [63:0] yb;
      logic [63:0] wa;
      logic [63:0] wb;
      logic [63:0] sizes;
      logic        valid;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [EXT_W-1:0]   ex;
      logic [EXT_W-1:0]   ey;
      logic [EXT_W-1:0]   ez;
   } box_type;

   typedef struct packed {
      logic [31:0] area;
      logic        eye;
      logic        inval;
   } rsp_type;

endpackage

### src/box_screen_area_core.sv
// ----------------------------------------------------------------------------
// box_screen_area_core
// Screen area in pixels of a projected oriented box.
// ----------------------------------------------------------------------------
// Boxes enter on the req_ stream, one beat per box; one result beat per box
// leaves on the rsp_ stream in order. The csr_ port loads the projection
// rows, pixel sizes and the valid bit; write it only while the block is idle.
// A two-stage front forms the box extent and feeds a four-entry queue. The
// corner engine takes a new box only after it has issued all eight corners
// of the last one, one a cycle, through a transform, a pipelined divider
// (x and y in parallel) and min/max tracking, then three area stages.
// Results land in an eight-entry output buffer; the engine starts a box only
// when the buffer has room for every box in flight, so a stalled receiver
// backs up into the queue and then into req_tready without losing a beat.
// Reset clears all control state and the configuration to zero; no beats
// are accepted in the reset cycle.
// ----------------------------------------------------------------------------
module box_screen_area_core import bsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // center_x, center_y, center_z, right_axis, up_axis, forward_axis,
   // half_x, half_y, half_z, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // area_pixels, eye_plane_crossed, projection_invalid, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   cfg_type             cfg_ff;
   logic                fq_valid, fq_ready, bq_valid, bq_ready;
   box_type             fq_data, bq_data;
   logic                res_valid;
   rsp_type             res_data;
   rsp_type             ob_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]   owp_ff, orp_ff;
   logic [OUT_AW:0]     ocnt_ff;
   logic                opop;
   rsp_type             ohead;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_PROJ_X_A:  cfg_ff.xa    <= csr_wdata;
            CSR_PROJ_X_B:  cfg_ff.xb    <= csr_wdata;
            CSR_PROJ_Y_A:  cfg_ff.ya    <= csr_wdata;
            CSR_PROJ_Y_B:  cfg_ff.yb    <= csr_wdata;
            CSR_PROJ_W_A:  cfg_ff.wa    <= csr_wdata;
            CSR_PROJ_W_B:  cfg_ff.wb    <= csr_wdata;
            CSR_PIX_SIZES: cfg_ff.sizes <= csr_wdata;
            CSR_PROJ_VLD:  cfg_ff.valid <= csr_wdata[0];
            default:       cfg_ff       <= cfg_ff;
         endcase
      end
   end

   bsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_data     (fq_data)
   );

   bsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_data)
   );

   bsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_data    (bq_data),
      .out_cnt   (ocnt_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   assign rsp_tvalid = ocnt_ff != '0;
   assign opop       = rsp_tvalid && rsp_tready;
   assign ohead      = ob_ff[orp_ff];
   assign rsp_tdata  = {6'b0, ohead.inval, ohead.eye, ohead.area};

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff  <= res_valid ? owp_ff + 1'b1 : owp_ff;
         orp_ff  <= opop ? orp_ff + 1'b1 : orp_ff;
         ocnt_ff <= ocnt_ff + (OUT_AW+1)'(res_valid) - (OUT_AW+1)'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) ob_ff[owp_ff] <= res_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (ocnt_ff != (OUT_AW+1)'(OUT_DEPTH) || opop))
      else $error("output buffer overflow");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("both flags set");

   a_inval_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33]) |-> rsp_tdata[31:0] == 32'd0)
      else $error("invalid projection with nonzero area");

   a_queue_ok: assert property (@(posedge clock) disable iff (reset)
      bq_ready |-> bq_valid)
      else $error("corner engine started without a box");

endmodule

### src/bsa_front.sv
// ----------------------------------------------------------------------------
// bsa_front
// Accepts boxes and forms the world-aligned half extent in two stages.
// ----------------------------------------------------------------------------
module bsa_front import bsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             q_valid,
   input  logic             q_ready,
   output box_type          q_data
);

   logic                s1_v_ff, s1_v_in;
   logic signed [31:0]  s1_c_ff [3];
   logic [46:0]         s1_p_ff [3][3];
   logic [46:0]         s1_p_in [3][3];
   logic                s2_v_ff, s2_v_in;
   box_type             s2_ff, s2_in;
   logic                s1_adv, s2_adv;
   logic [48:0]         esum [3];

   assign s2_adv     = !s2_v_ff || q_ready;
   assign s1_adv     = !s1_v_ff || s2_adv;
   assign req_tready = s1_adv && !reset;
   assign q_valid    = s2_v_ff;
   assign q_data     = s2_ff;

   always_comb begin
      logic [15:0] comp;
      logic [30:0] half;
      for (int k = 0; k < 3; k++) begin
         half = req_tdata[240 + 31*k +: 31];
         for (int a = 0; a < 3; a++) begin
            comp = req_tdata[96 + 48*k + 16*a +: 16];
            if (comp[15]) comp = 16'(-comp);
            s1_p_in[k][a] = 47'(comp) * 47'(half);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++)
         esum[a] = 49'(s1_p_ff[0][a]) + 49'(s1_p_ff[1][a]) + 49'(s1_p_ff[2][a]);
      s2_in.cx = s1_c_ff[0];
      s2_in.cy = s1_c_ff[1];
      s2_in.cz = s1_c_ff[2];
      s2_in.ex = esum[0][48:14];
      s2_in.ey = esum[1][48:14];
      s2_in.ez = esum[2][48:14];
   end

   assign s1_v_in = s1_adv ? req_tvalid : s1_v_ff;
   assign s2_v_in = s2_adv ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int k = 0; k < 3; k++) begin
            s1_c_ff[k] <= req_tdata[32*k +: 32];
            for (int a = 0; a < 3; a++) s1_p_ff[k][a] <= s1_p_in[k][a];
         end
      end
      if (s2_adv) s2_ff <= s2_in;
   end

endmodule

### src/bsa_queue.sv
// ----------------------------------------------------------------------------
// bsa_queue
// Short queue of boxes between the front and the corner engine.
// ----------------------------------------------------------------------------
module bsa_queue import bsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  box_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output box_type pop_data
);

   box_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign push_ready = cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign wp_in      = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in      = pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in     = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

### src/bsa_back.sv
// ----------------------------------------------------------------------------
// bsa_back
// Corner engine: one corner a cycle while a box is issuing, through transform,
// pipelined divide, min/max tracking and area.
// ----------------------------------------------------------------------------
module bsa_back import bsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_valid,
   output logic            q_ready,
   input  box_type         q_data,
   input  logic [OUT_AW:0] out_cnt,
   output logic            res_valid,
   output rsp_type         res_data
);

   typedef struct packed {
      logic [REM_W-1:0]  rx;
      logic [REM_W-1:0]  ry;
      logic [FRAC_W-1:0] qx;
      logic [FRAC_W-1:0] qy;
      logic [CLIP_W-1:0] den;
      logic [2:0]        fx;   // pos sat, neg sat, negative
      logic [2:0]        fy;
      logic              near;
      logic              first;
      logic              last;
   } div_type;

   function automatic logic signed [31:0] corner_coord(logic signed [31:0] c,
                                                       logic [EXT_W-1:0] e,
                                                       logic up);
      logic signed [EXT_W+1:0] s;
      s = up ? (EXT_W+2)'(c) + $signed({2'b00, e}) : (EXT_W+2)'(c) - $signed({2'b00, e});
      if (s > (EXT_W+2)'(32'sh7fffffff)) return 32'sh7fffffff;
      if (s < (EXT_W+2)'(-64'sh80000000)) return 32'sh80000000;
      return s[31:0];
   endfunction

   // issue
   logic            busy_ff, busy_in, start, issue;
   logic [2:0]      cnt_ff, cnt_in, corner;
   box_type         cur_ff, item;
   logic [OUT_AW:0] infl_ff, infl_in;
   logic            done;

   assign start   = !busy_ff && q_valid &&
                    ((OUT_AW+2)'(infl_ff) + (OUT_AW+2)'(out_cnt) < (OUT_AW+2)'(OUT_DEPTH));
   assign q_ready = start;
   assign issue   = start || busy_ff;
   assign item    = start ? q_data : cur_ff;
   assign corner  = busy_ff ? cnt_ff : 3'd0;
   assign cnt_in  = issue ? corner + 3'd1 : cnt_ff;
   assign busy_in = start ? 1'b1 : (busy_ff && cnt_ff == 3'd7) ? 1'b0 : busy_ff;
   assign infl_in = infl_ff + (OUT_AW+1)'(start) - (OUT_AW+1)'(done);

   // corner stage
   logic               s0_v_ff, s0_first_ff, s0_last_ff;
   logic signed [31:0] s0_p_ff [3];

   // product stage
   logic               s1_v_ff, s1_first_ff, s1_last_ff;
   logic signed [47:0] s1_m_ff [3][3];
   logic signed [47:0] s1_m_in [3][3];
   logic signed [31:0] coef [3][4];

   // clip sum stage
   logic                     s2_v_ff, s2_first_ff, s2_last_ff;
   logic signed [CLIP_W-1:0] s2_c_ff [3];
   logic signed [CLIP_W-1:0] s2_c_in [3];

   // divider
   logic    dv_v_ff [FRAC_W+1];
   div_type dv_ff [FRAC_W+1];
   div_type dv_in [FRAC_W+1];

   // ndc / accumulate / area
   logic                    n_v_ff, n_first_ff, n_last_ff, n_near_ff;
   logic signed [NDC_W-1:0] n_x_ff, n_y_ff, n_x_in, n_y_in;
   logic signed [NDC_W-1:0] mnx_ff, mxx_ff, mny_ff, mxy_ff;
   logic signed [NDC_W-1:0] mnx_in, mxx_in, mny_in, mxy_in;
   logic                    eye_ff, eye_in;
   logic                    f1_v_ff, f1_eye_ff, f2_v_ff, f2_eye_ff, f3_v_ff, f3_eye_ff;
   logic [NDC_W-1:0]        f1_dx_ff, f1_dy_ff;
   logic [33:0]             f2_px_ff, f2_py_ff;
   logic [67:0]             f3_prod_ff;
   logic [15:0]             w_sel, h_sel;

   always_comb begin
      coef[0][0] = cfg.xa[31:0];  coef[0][1] = cfg.xa[63:32];
      coef[0][2] = cfg.xb[31:0];  coef[0][3] = cfg.xb[63:32];
      coef[1][0] = cfg.ya[31:0];  coef[1][1] = cfg.ya[63:32];
      coef[1][2] = cfg.yb[31:0];  coef[1][3] = cfg.yb[63:32];
      coef[2][0] = cfg.wa[31:0];  coef[2][1] = cfg.wa[63:32];
      coef[2][2] = cfg.wb[31:0];  coef[2][3] = cfg.wb[63:32];
   end

   always_comb begin
      logic signed [63:0] prod;
      for (int r = 0; r < 3; r++)
         for (int a = 0; a < 3; a++) begin
            prod = 64'(coef[r][a]) * 64'(s0_p_ff[a]);
            s1_m_in[r][a] = prod[63:16];
         end
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         s2_c_in[r] = CLIP_W'(coef[r][3]) + CLIP_W'(s1_m_ff[r][0]) +
                      CLIP_W'(s1_m_ff[r][1]) + CLIP_W'(s1_m_ff[r][2]);
   end

   always_comb begin
      logic signed [CLIP_W-1:0] cx, cy, cw;
      logic [REM_W-1:0] sh;
      cx = s2_c_ff[0];
      cy = s2_c_ff[1];
      cw = s2_c_ff[2];
      dv_in[0].rx    = cx[CLIP_W-1] ? REM_W'(-cx) : REM_W'(cx);
      dv_in[0].ry    = cy[CLIP_W-1] ? REM_W'(-cy) : REM_W'(cy);
      dv_in[0].qx    = '0;
      dv_in[0].qy    = '0;
      dv_in[0].den   = cw;
      dv_in[0].fx    = {cx >= cw, cx <= -cw, cx[CLIP_W-1]};
      dv_in[0].fy    = {cy >= cw, cy <= -cw, cy[CLIP_W-1]};
      dv_in[0].near  = cw <= NEAR_W;
      dv_in[0].first = s2_first_ff;
      dv_in[0].last  = s2_last_ff;
      for (int i = 1; i <= FRAC_W; i++) begin
         dv_in[i] = dv_ff[i-1];
         sh = {dv_ff[i-1].rx[REM_W-2:0], 1'b0};
         if (sh >= REM_W'(dv_ff[i-1].den)) begin
            dv_in[i].rx = sh - REM_W'(dv_ff[i-1].den);
            dv_in[i].qx = {dv_ff[i-1].qx[FRAC_W-2:0], 1'b1};
         end else begin
            dv_in[i].rx = sh;
            dv_in[i].qx = {dv_ff[i-1].qx[FRAC_W-2:0], 1'b0};
         end
         sh = {dv_ff[i-1].ry[REM_W-2:0], 1'b0};
         if (sh >= REM_W'(dv_ff[i-1].den)) begin
            dv_in[i].ry = sh - REM_W'(dv_ff[i-1].den);
            dv_in[i].qy = {dv_ff[i-1].qy[FRAC_W-2:0], 1'b1};
         end else begin
            dv_in[i].ry = sh;
            dv_in[i].qy = {dv_ff[i-1].qy[FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      div_type d;
      d = dv_ff[FRAC_W];
      if (d.fx[2])      n_x_in = NDC_ONE;
      else if (d.fx[1]) n_x_in = -NDC_ONE;
      else if (d.fx[0]) n_x_in = -$signed({2'b00, d.qx});
      else              n_x_in = $signed({2'b00, d.qx});
      if (d.fy[2])      n_y_in = NDC_ONE;
      else if (d.fy[1]) n_y_in = -NDC_ONE;
      else if (d.fy[0]) n_y_in = -$signed({2'b00, d.qy});
      else              n_y_in = $signed({2'b00, d.qy});
   end

   always_comb begin
      logic signed [NDC_W-1:0] a_mnx, a_mxx, a_mny, a_mxy;
      a_mnx  = n_first_ff ? NDC_ONE  : mnx_ff;
      a_mxx  = n_first_ff ? -NDC_ONE : mxx_ff;
      a_mny  = n_first_ff ? NDC_ONE  : mny_ff;
      a_mxy  = n_first_ff ? -NDC_ONE : mxy_ff;
      mnx_in = n_x_ff < a_mnx ? n_x_ff : a_mnx;
      mxx_in = n_x_ff > a_mxx ? n_x_ff : a_mxx;
      mny_in = n_y_ff < a_mny ? n_y_ff : a_mny;
      mxy_in = n_y_ff > a_mxy ? n_y_ff : a_mxy;
      eye_in = (n_first_ff ? 1'b0 : eye_ff) | n_near_ff;
   end

   always_comb begin
      w_sel = cfg.sizes[15:0];
      h_sel = cfg.sizes[31:16];
      if (w_sel == '0 || h_sel == '0) begin
         w_sel = cfg.sizes[47:32];
         h_sel = cfg.sizes[63:48];
      end
   end

   assign done      = f3_v_ff;
   assign res_valid = f3_v_ff;

   always_comb begin
      res_data.inval = !cfg.valid;
      res_data.eye   = cfg.valid && f3_eye_ff;
      if (!cfg.valid)     res_data.area = '0;
      else if (f3_eye_ff) res_data.area = '1;
      else                res_data.area = f3_prod_ff[65:34];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         infl_ff <= '0;
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         for (int i = 0; i <= FRAC_W; i++) dv_v_ff[i] <= 1'b0;
         n_v_ff  <= 1'b0;
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         infl_ff <= infl_in;
         s0_v_ff <= issue;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         dv_v_ff[0] <= s2_v_ff;
         for (int i = 1; i <= FRAC_W; i++) dv_v_ff[i] <= dv_v_ff[i-1];
         n_v_ff  <= dv_v_ff[FRAC_W];
         f1_v_ff <= n_v_ff && n_last_ff;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) cur_ff <= q_data;
      s0_p_ff[0]  <= corner_coord(item.cx, item.ex, corner[0]);
      s0_p_ff[1]  <= corner_coord(item.cy, item.ey, corner[1]);
      s0_p_ff[2]  <= corner_coord(item.cz, item.ez, corner[2]);
      s0_first_ff <= corner == 3'd0;
      s0_last_ff  <= corner == 3'd7;
      s1_m_ff     <= s1_m_in;
      s1_first_ff <= s0_first_ff;
      s1_last_ff  <= s0_last_ff;
      s2_c_ff     <= s2_c_in;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      for (int i = 0; i <= FRAC_W; i++) dv_ff[i] <= dv_in[i];
      n_x_ff     <= n_x_in;
      n_y_ff     <= n_y_in;
      n_near_ff  <= dv_ff[FRAC_W].near;
      n_first_ff <= dv_ff[FRAC_W].first;
      n_last_ff  <= dv_ff[FRAC_W].last;
      if (n_v_ff) begin
         mnx_ff <= mnx_in;
         mxx_ff <= mxx_in;
         mny_ff <= mny_in;
         mxy_ff <= mxy_in;
         eye_ff <= eye_in;
      end
      f1_dx_ff   <= NDC_W'(mxx_in - mnx_in);
      f1_dy_ff   <= NDC_W'(mxy_in - mny_in);
      f1_eye_ff  <= eye_in;
      f2_px_ff   <= 34'(f1_dx_ff) * 34'(w_sel);
      f2_py_ff   <= 34'(f1_dy_ff) * 34'(h_sel);
      f2_eye_ff  <= f1_eye_ff;
      f3_prod_ff <= 68'(f2_px_ff) * 68'(f2_py_ff);
      f3_eye_ff  <= f2_eye_ff;
   end

endmodule
